// ===== sv/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables shared by the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } md5_fsm_t;

  // Working variables of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_vars_t;

  // Initial chaining words
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;

  // Padding constants
  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] FILL_LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [1:0] WORD_LAST = 2'd3;

  // Additive constant of each round
  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left-rotate amount: depends on the stage and the low two round bits
  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] rl;
    logic [3:0] g;
    rl = r[3:0];
    unique case (r[5:4])
      2'd0: g = rl;
      2'd1: g = rl * 4'd5 + 4'd1;
      2'd2: g = rl * 4'd3 + 4'd5;
      2'd3: g = rl * 4'd7;
      default: g = rl;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/md5_round.sv =====
// ----------------------------------------------------------------------------
// md5_round
// One MD5 round: the shared step that the controller applies 64 times a block.
// ----------------------------------------------------------------------------
module md5_round
  import md5_pkg::*;
(
  input  md5_vars_t   vars,
  input  logic [31:0] msg_word,
  input  logic [5:0]  rnd,
  output md5_vars_t   vars_next
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [4:0]  amt;

  // Round function by stage
  always_comb begin
    case (rnd[5:4])
      2'd0: f = (vars.b & vars.c) | (~vars.b & vars.d);
      2'd1: f = (vars.b & vars.d) | (vars.c & ~vars.d);
      2'd2: f = vars.b ^ vars.c ^ vars.d;
      default: f = vars.c ^ (vars.b | ~vars.d);
    endcase
  end

  // Sum, rotate, add; then shift the variables along
  assign amt      = rot_amount(rnd);
  assign sum      = vars.a + f + round_const(rnd) + msg_word;
  assign rot_wide = {sum, sum} << amt;

  assign vars_next.a = vars.d;
  assign vars_next.d = vars.c;
  assign vars_next.c = vars.b;
  assign vars_next.b = vars.b + rot_wide[63:32];

endmodule

// ===== sv/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one byte per input item.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry data_byte, byte_present and
// message_end. An item with byte_present low adds no byte; with message_end
// high it closes the message (an empty message is one such item).
// Output channel: out_valid / out_stall carry the four chaining words h0..h3
// in order; word_index names each word and digest_last marks the fourth.
// After the item that fills a 64-byte block, in_stall stays high while the
// 64 rounds run through the one round unit and the result is then folded
// into the chaining words.
// The closing item pads one byte per cycle (0x80, zeros, an idle step at
// byte 56, 8 length bytes), pausing for one or two compressions on the
// way, before the digest words are offered.
// A stalled output word holds; the block takes no input until all four
// words are taken, then returns to the initial chaining values.
// Reset (rst, synchronous) loads the initial values and clears the counts.
// ----------------------------------------------------------------------------
module md5_message_digest
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        digest_last
);

  md5_fsm_t    state, state_next;
  md5_fsm_t    ret_state, ret_state_next;
  logic [31:0] chain [4];
  logic [31:0] block_words [16];
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [5:0]  rnd;
  logic [1:0]  out_idx;
  md5_vars_t   vars;
  md5_vars_t   vars_next;

  logic        in_take;
  logic        out_take;
  logic        push;
  logic [7:0]  push_byte;
  logic        block_full;

  assign in_take    = in_valid && !in_stall;
  assign out_take   = out_valid && !out_stall;
  assign block_full = push && (fill == FILL_LAST);

  // Shared round unit
  md5_round u_round (
    .vars      (vars),
    .msg_word  (block_words[msg_index(rnd)]),
    .rnd       (rnd),
    .vars_next (vars_next)
  );

  // Next state
  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (block_full) begin
            state_next     = ST_COMP;
            ret_state_next = message_end ? ST_PAD_MARK : ST_IDLE;
          end else if (message_end) begin
            state_next = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        if (block_full) begin
          state_next     = ST_COMP;
          ret_state_next = ST_PAD_ZERO;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (fill == FILL_LEN_START) begin
          state_next = ST_PAD_LEN;
        end else if (block_full) begin
          state_next     = ST_COMP;
          ret_state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        if (block_full) begin
          state_next     = ST_COMP;
          ret_state_next = ST_OUT;
        end
      end
      ST_COMP: begin
        if (rnd == ROUND_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_next = ret_state;
      end
      ST_OUT: begin
        if (out_take && out_idx == WORD_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    push      = 1'b0;
    push_byte = data_byte;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        push     = in_valid && byte_present;
      end
      ST_PAD_MARK: begin
        push      = 1'b1;
        push_byte = PAD_MARK_BYTE;
      end
      ST_PAD_ZERO: begin
        push      = (fill != FILL_LEN_START);
        push_byte = 8'h00;
      end
      ST_PAD_LEN: begin
        push      = 1'b1;
        push_byte = bit_count[{fill[2:0], 3'b000} +: 8];
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign digest_last = (out_idx == WORD_LAST);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  // Fill, length, round and output counters; chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_count <= '0;
      rnd       <= '0;
      out_idx   <= '0;
      chain[0]  <= H0_INIT;
      chain[1]  <= H1_INIT;
      chain[2]  <= H2_INIT;
      chain[3]  <= H3_INIT;
    end else begin
      if (push) begin
        fill <= fill + 6'd1;
      end
      if (in_take && byte_present) begin
        bit_count <= bit_count + 64'd8;
      end
      if (state == ST_COMP) begin
        rnd <= rnd + 6'd1;
      end
      if (state == ST_FOLD) begin
        chain[0] <= chain[0] + vars.a;
        chain[1] <= chain[1] + vars.b;
        chain[2] <= chain[2] + vars.c;
        chain[3] <= chain[3] + vars.d;
      end
      if (out_take) begin
        out_idx <= out_idx + 2'd1;
        if (out_idx == WORD_LAST) begin
          fill      <= '0;
          bit_count <= '0;
          chain[0]  <= H0_INIT;
          chain[1]  <= H1_INIT;
          chain[2]  <= H2_INIT;
          chain[3]  <= H3_INIT;
        end
      end
    end
  end

  // Block buffer: one byte lane written per push
  always_ff @(posedge clk) begin
    if (push) begin
      block_words[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= push_byte;
    end
  end

  // Working variables: loaded when a block fills, stepped each round
  always_ff @(posedge clk) begin
    if (block_full) begin
      vars.a <= chain[0];
      vars.b <= chain[1];
      vars.c <= chain[2];
      vars.d <= chain[3];
    end else if (state == ST_COMP) begin
      vars <= vars_next;
    end
  end

endmodule

// ===== sim/md5_digest_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_digest_checker
// Watches both channels of the MD5 digest block, keeps its own running MD5
// state, queues the four digest words each closing item should produce and
// compares every accepted output word against the oldest queued word.
// ----------------------------------------------------------------------------
module md5_digest_checker
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [1:0]  word_index,
  input  logic        digest_last,
  output int          fail_count,
  output int          pending_words,
  output int          digests_checked,
  output int          items_seen
);

  // Additive constant of each round, round 0 in the top word
  localparam bit [2047:0] SINE_TABLE = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts: four per stage, stage 0 first
  localparam bit [79:0] SHIFT_TABLE = {
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    bit [31:0] word;
    bit [1:0]  idx;
    bit        last;
  } md5_out_t;

  // Running hash state
  bit [31:0]   chain_h [4];
  bit [31:0]   block_w [16];
  int unsigned block_bytes;
  bit [63:0]   msg_bits;

  md5_out_t expected_digest_q [$];

  function automatic bit [31:0] rotl32(bit [31:0] v, int unsigned n);
    if (n == 0) return v;
    return (v << n) | (v >> (32 - n));
  endfunction

  // One 64-round compression of block_w into chain_h
  function automatic void md5_compress();
    bit [31:0]   a, b, c, d, f, t, k;
    int unsigned r, g, stage;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    for (r = 0; r < 64; r++) begin
      stage = r >> 4;
      case (stage)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      k = SINE_TABLE[(63 - r) * 32 +: 32];
      t = d;
      d = c;
      c = b;
      b = b + rotl32(a + f + k + block_w[g],
                     SHIFT_TABLE[(15 - (stage * 4 + r % 4)) * 5 +: 5]);
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
  endfunction

  // Little-endian byte packing; a full block compresses at once
  function automatic void absorb_byte(bit [7:0] b);
    int unsigned w, lane;
    w = block_bytes >> 2;
    lane = block_bytes % 4;
    if (lane == 0) block_w[w] = {24'd0, b};
    else block_w[w][lane * 8 +: 8] = b;
    block_bytes++;
    if (block_bytes == 64) begin
      md5_compress();
      block_bytes = 0;
    end
  endfunction

  function automatic void restart_hash();
    chain_h[0] = H0_INIT;
    chain_h[1] = H1_INIT;
    chain_h[2] = H2_INIT;
    chain_h[3] = H3_INIT;
    block_bytes = 0;
    msg_bits = '0;
  endfunction

  // Advance the hash by one input item; a closing item pads and queues the digest
  function automatic void hash_item(bit [7:0] b, bit present, bit closing);
    bit [63:0] len;
    md5_out_t  o;
    int        i;
    if (present) begin
      absorb_byte(b);
      msg_bits += 64'd8;
    end
    if (!closing) return;
    len = msg_bits;
    absorb_byte(PAD_MARK_BYTE);
    while (block_bytes != 56) absorb_byte(8'h00);
    for (i = 0; i < 8; i++) absorb_byte(len[8 * i +: 8]);
    for (i = 0; i < 4; i++) begin
      o.word = chain_h[i];
      o.idx = i[1:0];
      o.last = (i == 3);
      expected_digest_q.push_back(o);
    end
    restart_hash();
  endfunction

  task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Sample both channels at each rising edge
  always @(posedge clk) begin
    md5_out_t o;
    if (rst) begin
      restart_hash();
      expected_digest_q.delete();
      fail_count = 0;
      digests_checked = 0;
      items_seen = 0;
    end else begin
      if (in_valid && !in_stall) begin
        hash_item(data_byte, byte_present, message_end);
        items_seen++;
      end
      if (out_valid && !out_stall) begin
        if (expected_digest_q.size() == 0) begin
          report_mismatch("unexpected digest word", digest_word, 32'd0);
        end else begin
          o = expected_digest_q.pop_front();
          if (digest_word !== o.word)
            report_mismatch("digest_word", digest_word, o.word);
          if (word_index !== o.idx)
            report_mismatch("word_index", 32'(word_index), 32'(o.idx));
          if (digest_last !== o.last)
            report_mismatch("digest_last", 32'(digest_last), 32'(o.last));
          if (o.last) digests_checked++;
        end
      end
    end
    pending_words <= expected_digest_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the MD5 digest block. Sends directed messages
// (empty message, no-op items, short strings, extreme bytes) and then random
// messages of short and block-boundary lengths, with random gaps and output
// stalls, including long output hold-offs that back up the input.
// ----------------------------------------------------------------------------
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        digest_last;

  int fail_count;
  int pending_words;
  int digests_checked;
  int items_seen;

  // Traffic shaping shared by sender and receiver
  bit burst_mode = 1'b0;
  bit quick_drain = 1'b0;
  bit hold_request = 1'b0;
  int items_sent = 0;

  md5_message_digest u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .digest_last  (digest_last)
  );

  md5_digest_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .byte_present    (byte_present),
    .message_end     (message_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digest_word     (digest_word),
    .word_index      (word_index),
    .digest_last     (digest_last),
    .fail_count      (fail_count),
    .pending_words   (pending_words),
    .digests_checked (digests_checked),
    .items_seen      (items_seen)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one item after a random gap (none in burst mode) and hold it until accepted
  task automatic send_item(input bit [7:0] b, input bit present, input bit closing);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= present;
    message_end <= closing;
    do @(posedge clk); while (in_stall);
    if (present || closing) items_sent++;
  endtask

  // Random message; may be closed by an empty item and sprinkled with no-op items
  task automatic send_message(input int len, input bit empty_close);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !empty_close);
    end
    if (len == 0 || empty_close) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Receiver: random stall before each word, long hold-off on request
  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      wait_cycles = quick_drain ? 0 : $urandom_range(0, 15);
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles = 400;
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin
    int msgs;
    int len;
    int guard;
    bit leftover;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, no-op item, "abc" with a gap item, extreme bytes
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);

    // Random messages: mostly short, some at the padding boundaries
    msgs = 0;
    while (items_sent < 150) begin
      if ($urandom_range(0, 5) == 0) burst_mode = !burst_mode;
      if ($urandom_range(0, 5) == 0) quick_drain = !quick_drain;
      if (msgs == 0 || msgs == 4) hold_request = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          3: len = 64;
          4: len = 65;
          default: len = 119;
        endcase
      end else begin
        len = $urandom_range(0, 9);
      end
      send_message(len, $urandom_range(0, 3) == 0);
      msgs++;
    end
    in_valid <= 1'b0;

    // Drain outstanding digest words, then let the block settle
    @(posedge clk);
    guard = 0;
    while (pending_words != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    leftover = (pending_words != 0);
    if (leftover) $display("%0d digest words never arrived", pending_words);

    $display("Hashed %0d items into %0d checked digests: empty, short, and", items_seen,
             digests_checked);
    $display("block-boundary messages under random gaps, stalls and long hold-offs.");
    if (fail_count == 0 && !leftover) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== md5_message_digest.f =====
sv/md5_pkg.sv
sv/md5_round.sv
sv/md5_message_digest.sv
sim/md5_digest_checker.sv
sim/tb.sv
